FILE: sv/wav_pcm_stream_parser_assert.svh
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset
`define WPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset
`define WPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/wpp_pkg.sv
package wpp_pkg;

  // Chunk tags as little-endian 32-bit words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Result kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NO_RIFF     = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE     = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM     = 3'd2;
  localparam logic [2:0] ERR_PAST_END    = 3'd3;
  localparam logic [2:0] ERR_DATA_EARLY  = 3'd4;
  localparam logic [2:0] ERR_ZERO_FRAME  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } wpp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_value;
    logic [15:0] channel;
    logic        end_of_data;
    logic [2:0]  error_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
  } wpp_out_t;

endpackage

FILE: sv/wav_pcm_stream_parser.sv
// WAV PCM stream parser. Takes a RIFF/WAVE file one byte per item on the in_
// channel (restart marks the first byte of a new file) and gives at most one
// result item per byte on the out_ channel: a raw little-endian sample with its
// channel index, the fmt report, an error, or a bare end-of-data mark. One byte
// is taken every clock cycle while results are taken; a byte passes the input
// register, then the parse step, which updates the parser state and loads the
// result register; while the result register is stalled, the byte waits in the
// input register. The parse step sets the rate at one byte per clock while
// results are taken.
module wav_pcm_stream_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wpp_pkg::wpp_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output wpp_pkg::wpp_out_t out_item
);
  import wpp_pkg::*;

  logic     in_valid_r;
  wpp_in_t  in_item_r;
  logic     out_valid_r;
  wpp_out_t out_item_r;
  logic     fire;
  logic     res_valid;
  wpp_out_t res;

  // Parse step fires when the input register holds a byte and the result register is free or being emptied
  assign fire     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  wpp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: sv/wpp_core.sv
module wpp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  wpp_pkg::wpp_in_t  item,
  output logic            res_valid,
  output wpp_pkg::wpp_out_t res
);
  import wpp_pkg::*;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_TAG   = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_SKIP  = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_PAD   = 4'd8;
  localparam logic [3:0] PH_IDLE  = 4'd9;

  // OR a byte into lane n of a 32-bit word
  function automatic logic [31:0] lane_or(input logic [31:0] w, input logic [7:0] b,
                                          input logic [1:0] n);
    logic [31:0] r;
    r = w;
    case (n)
      2'd0:    r = w | {24'd0, b};
      2'd1:    r = w | {16'd0, b, 8'd0};
      2'd2:    r = w | {8'd0, b, 16'd0};
      2'd3:    r = w | {b, 24'd0};
      default: r = w;
    endcase
    return r;
  endfunction

  // Parser state
  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  fbc_r, fbc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] riff_left_r, riff_left_nxt;
  logic [31:0] chunk_left_r, chunk_left_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] fsize_r, fsize_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [15:0] fidx_r, fidx_nxt;
  logic        short_r, short_nxt;
  logic [1:0]  off_r, off_nxt;     // byte offset within the sample
  logic [15:0] ch_r, ch_nxt;       // channel of the sample being built

  // State as seen by this item (restart forces the reset view)
  logic [3:0]  phase_c;
  logic [1:0]  fbc_c;
  logic [31:0] acc_c, riff_left_c, chunk_left_c, tag_c, rate_c;
  logic [15:0] chans_c, fsize_c, depth_c, fidx_c, ch_c;
  logic        fmt_seen_c, short_c;
  logic [1:0]  off_c;

  // Helpers
  logic [7:0]  b;
  logic [31:0] word_acc, word_tag, cl_dec, data_acc, fmt_acc, rate_f;
  logic [15:0] chans_f, fsize_f, depth_f;
  logic        word_done, cl_zero, nb_ok, short_eff, emit, p_wrap;
  logic [1:0]  fbc_inc, last_off;
  logic [3:0]  k;
  logic [4:0]  k1;
  logic [16:0] p_inc;

  assign b = item.data_byte;

  always_comb begin
    // restart view of the state
    phase_c      = item.restart ? PH_RIFF : phase_r;
    fbc_c        = item.restart ? 2'd0    : fbc_r;
    acc_c        = item.restart ? 32'd0   : acc_r;
    riff_left_c  = item.restart ? 32'd0   : riff_left_r;
    chunk_left_c = item.restart ? 32'd0   : chunk_left_r;
    tag_c        = item.restart ? 32'd0   : tag_r;
    chans_c      = item.restart ? 16'd0   : chans_r;
    rate_c       = item.restart ? 32'd0   : rate_r;
    fsize_c      = item.restart ? 16'd0   : fsize_r;
    depth_c      = item.restart ? 16'd0   : depth_r;
    fmt_seen_c   = item.restart ? 1'b0    : fmt_seen_r;
    fidx_c       = item.restart ? 16'd0   : fidx_r;
    short_c      = item.restart ? 1'b0    : short_r;
    off_c        = item.restart ? 2'd0    : off_r;
    ch_c         = item.restart ? 16'd0   : ch_r;

    // defaults: hold
    phase_nxt      = phase_c;
    fbc_nxt        = fbc_c;
    acc_nxt        = acc_c;
    riff_left_nxt  = riff_left_c;
    chunk_left_nxt = chunk_left_c;
    tag_nxt        = tag_c;
    chans_nxt      = chans_c;
    rate_nxt       = rate_c;
    fsize_nxt      = fsize_c;
    depth_nxt      = depth_c;
    fmt_seen_nxt   = fmt_seen_c;
    fidx_nxt       = fidx_c;
    short_nxt      = short_c;
    off_nxt        = off_c;
    ch_nxt         = ch_c;
    res_valid      = 1'b0;
    res            = '0;

    // little-endian word collection for tags and sizes
    fbc_inc   = fbc_c + 2'd1;
    word_done = (fbc_c == 2'd3);
    word_acc  = lane_or((fbc_c == 2'd0) ? 32'd0 : acc_c, b, fbc_c);
    word_tag  = lane_or((fbc_c == 2'd0) ? 32'd0 : tag_c, b, fbc_c);
    cl_dec    = chunk_left_c - 32'd1;
    cl_zero   = (cl_dec == 32'd0);

    // fmt body field capture
    k       = fidx_c[3:0];
    k1      = {1'b0, k} + 5'd1;
    fmt_acc = acc_c;
    chans_f = chans_c;
    rate_f  = rate_c;
    fsize_f = fsize_c;
    depth_f = depth_c;
    if (k < 4'd2) begin
      fmt_acc = lane_or(acc_c, b, k[1:0]);
    end else if (k < 4'd4) begin
      chans_f = k[0] ? (chans_c | {b, 8'd0}) : (chans_c | {8'd0, b});
    end else if (k < 4'd8) begin
      rate_f = lane_or(rate_c, b, k[1:0]);
    end else if (k >= 4'd12 && k < 4'd14) begin
      fsize_f = k[0] ? (fsize_c | {b, 8'd0}) : (fsize_c | {8'd0, b});
    end else if (k >= 4'd14) begin
      depth_f = k[0] ? (depth_c | {b, 8'd0}) : (depth_c | {8'd0, b});
    end

    // sample size from bit depth
    nb_ok    = 1'b1;
    last_off = 2'd0;
    case (depth_c)
      16'd8:   last_off = 2'd0;
      16'd16:  last_off = 2'd1;
      16'd24:  last_off = 2'd2;
      16'd32:  last_off = 2'd3;
      default: nb_ok = 1'b0;
    endcase
    short_eff = (fidx_c == 16'd0) ? (chunk_left_c < {16'd0, fsize_c}) : short_c;
    data_acc  = (off_c == 2'd0) ? {24'd0, b} : lane_or(acc_c, b, off_c);
    emit      = nb_ok && (off_c == last_off) && (ch_c < chans_c) && !short_eff;
    p_inc     = {1'b0, fidx_c} + 17'd1;
    p_wrap    = (p_inc >= {1'b0, fsize_c});

    case (phase_c)
      PH_RIFF: begin
        tag_nxt = word_tag;
        fbc_nxt = fbc_inc;
        if (word_done) begin
          if (word_tag != TAG_RIFF) begin
            phase_nxt      = PH_IDLE;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_NO_RIFF;
          end else begin
            phase_nxt = PH_RSIZE;
          end
        end
      end
      PH_RSIZE: begin
        acc_nxt = word_acc;
        fbc_nxt = fbc_inc;
        if (word_done) begin
          riff_left_nxt = word_acc;
          phase_nxt     = PH_WAVE;
        end
      end
      PH_IDLE: begin
      end
      default: begin
        if (riff_left_c == 32'd0) begin
          // byte beyond the RIFF size
          phase_nxt      = PH_IDLE;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_PAST_END;
        end else begin
          riff_left_nxt = riff_left_c - 32'd1;
          case (phase_c)
            PH_WAVE: begin
              tag_nxt = word_tag;
              fbc_nxt = fbc_inc;
              if (word_done) begin
                if (word_tag != TAG_WAVE) begin
                  phase_nxt      = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_NO_WAVE;
                end else begin
                  phase_nxt = PH_TAG;
                end
              end
            end
            PH_TAG: begin
              tag_nxt = word_tag;
              fbc_nxt = fbc_inc;
              if (word_done) begin
                if (word_tag == TAG_DATA && !fmt_seen_c) begin
                  phase_nxt      = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_DATA_EARLY;
                end else begin
                  phase_nxt = PH_CSIZE;
                end
              end
            end
            PH_CSIZE: begin
              acc_nxt = word_acc;
              fbc_nxt = fbc_inc;
              if (word_done) begin
                chunk_left_nxt = word_acc;
                fbc_nxt        = {1'b0, word_acc[0]};
                fidx_nxt       = 16'd0;
                off_nxt        = 2'd0;
                ch_nxt         = 16'd0;
                if (tag_c == TAG_FMT) begin
                  chans_nxt    = 16'd0;
                  rate_nxt     = 32'd0;
                  fsize_nxt    = 16'd0;
                  depth_nxt    = 16'd0;
                  fmt_seen_nxt = 1'b0;
                  acc_nxt      = 32'd0;
                  if (word_acc == 32'd0) begin
                    phase_nxt      = PH_IDLE;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.error_code = ERR_NOT_PCM;
                  end else begin
                    phase_nxt = PH_FMT;
                  end
                end else if (word_acc == 32'd0) begin
                  // empty chunk, even size: straight to the next tag
                  phase_nxt = PH_TAG;
                  fbc_nxt   = 2'd0;
                  if (tag_c == TAG_DATA) begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_END;
                    res.end_of_data = 1'b1;
                  end
                end else begin
                  phase_nxt = (tag_c == TAG_DATA) ? PH_DATA : PH_SKIP;
                end
              end
            end
            PH_FMT: begin
              acc_nxt        = fmt_acc;
              chans_nxt      = chans_f;
              rate_nxt       = rate_f;
              fsize_nxt      = fsize_f;
              depth_nxt      = depth_f;
              chunk_left_nxt = cl_dec;
              fidx_nxt       = {11'd0, k1};
              if ((k1 == 5'd2 && fmt_acc[15:0] != 16'd1) || (cl_zero && k1 < 5'd2)) begin
                phase_nxt      = PH_IDLE;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NOT_PCM;
              end else if (k1 == 5'd16 || cl_zero) begin
                if (fsize_f == 16'd0) begin
                  phase_nxt      = PH_IDLE;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_ZERO_FRAME;
                end else begin
                  fmt_seen_nxt = 1'b1;
                  if (cl_zero) begin
                    phase_nxt = fbc_c[0] ? PH_PAD : PH_TAG;
                    fbc_nxt   = 2'd0;
                  end else begin
                    phase_nxt = PH_SKIP;
                  end
                  res_valid         = 1'b1;
                  res.kind          = KIND_FORMAT;
                  res.channel_count = chans_f;
                  res.rate_hz       = rate_f;
                  res.frame_bytes   = fsize_f;
                  res.sample_bits   = depth_f;
                end
              end
            end
            PH_SKIP: begin
              chunk_left_nxt = cl_dec;
              if (cl_zero) begin
                phase_nxt = fbc_c[0] ? PH_PAD : PH_TAG;
                fbc_nxt   = 2'd0;
              end
            end
            PH_PAD: begin
              phase_nxt = PH_TAG;
              fbc_nxt   = 2'd0;
            end
            PH_DATA: begin
              short_nxt      = short_eff;
              chunk_left_nxt = cl_dec;
              if (nb_ok) begin
                acc_nxt = data_acc;
              end
              // frame position and per-sample counters
              if (p_wrap) begin
                fidx_nxt = 16'd0;
                off_nxt  = 2'd0;
                ch_nxt   = 16'd0;
              end else begin
                fidx_nxt = p_inc[15:0];
                if (off_c == last_off) begin
                  off_nxt = 2'd0;
                  ch_nxt  = ch_c + 16'd1;
                end else begin
                  off_nxt = off_c + 2'd1;
                end
              end
              if (cl_zero) begin
                phase_nxt = fbc_c[0] ? PH_PAD : PH_TAG;
                fbc_nxt   = 2'd0;
              end
              if (emit) begin
                res_valid        = 1'b1;
                res.kind         = KIND_SAMPLE;
                res.sample_value = data_acc;
                res.channel      = ch_c;
                res.end_of_data  = cl_zero;
              end else if (cl_zero) begin
                res_valid       = 1'b1;
                res.kind        = KIND_END;
                res.end_of_data = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // State registers advance once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_RIFF;
      fbc_r        <= 2'd0;
      acc_r        <= 32'd0;
      riff_left_r  <= 32'd0;
      chunk_left_r <= 32'd0;
      tag_r        <= 32'd0;
      chans_r      <= 16'd0;
      rate_r       <= 32'd0;
      fsize_r      <= 16'd0;
      depth_r      <= 16'd0;
      fmt_seen_r   <= 1'b0;
      fidx_r       <= 16'd0;
      short_r      <= 1'b0;
      off_r        <= 2'd0;
      ch_r         <= 16'd0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      fbc_r        <= fbc_nxt;
      acc_r        <= acc_nxt;
      riff_left_r  <= riff_left_nxt;
      chunk_left_r <= chunk_left_nxt;
      tag_r        <= tag_nxt;
      chans_r      <= chans_nxt;
      rate_r       <= rate_nxt;
      fsize_r      <= fsize_nxt;
      depth_r      <= depth_nxt;
      fmt_seen_r   <= fmt_seen_nxt;
      fidx_r       <= fidx_nxt;
      short_r      <= short_nxt;
      off_r        <= off_nxt;
      ch_r         <= ch_nxt;
    end
  end

endmodule

FILE: sv/wpp_checker.sv
`include "wav_pcm_stream_parser_assert.svh"

module wpp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input wpp_pkg::wpp_out_t out_item
);
  import wpp_pkg::*;

  // A stalled result item holds
  `WPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_item), "result item changed while stalled")

  // Error items carry a defined code
  `WPP_ASSERT_NOW(a_err_code, clk, rst_n, out_valid && out_item.kind == KIND_ERROR,
                  out_item.error_code <= ERR_ZERO_FRAME, "undefined error code")

  // A format report never shows a zero frame size
  `WPP_ASSERT_NOW(a_fmt_frame, clk, rst_n, out_valid && out_item.kind == KIND_FORMAT,
                  out_item.frame_bytes != 16'd0, "format report with zero frame size")

  // End of data only on sample or end items
  `WPP_ASSERT_NOW(a_eod_kind, clk, rst_n, out_valid && out_item.end_of_data,
                  out_item.kind == KIND_SAMPLE || out_item.kind == KIND_END,
                  "end of data on wrong kind")

  // Sample fields stay zero outside sample items
  `WPP_ASSERT_NOW(a_sample_zero, clk, rst_n, out_valid && out_item.kind != KIND_SAMPLE,
                  out_item.sample_value == 32'd0 && out_item.channel == 16'd0,
                  "sample fields set on non-sample item")

endmodule

bind wav_pcm_stream_parser wpp_checker u_wpp_checker (.*);
